// ===== rtl/pisd_pkg.sv =====
package pisd_pkg;

   localparam int MaxVertices = 64;
   localparam int IdxW = $clog2(MaxVertices);
   localparam int CntW = IdxW + 1;
   localparam int CoordW = 24;
   localparam int ValW = 48;
   localparam int DsqW = 50;
   localparam logic [ValW-1:0] Sat48 = {ValW{1'b1}};

   typedef struct packed {
      logic signed [CoordW-1:0] x_coord;
      logic signed [CoordW-1:0] y_coord;
      logic                     last_vertex;
   } req_type;

   typedef struct packed {
      logic [IdxW-1:0] vertex_index;
      logic [ValW-1:0] near_density;
      logic [ValW-1:0] total_score;
      logic            saturated;
      logic            last_result;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic            store_wr;
      logic [IdxW-1:0] store_addr;
      logic [IdxW-1:0] rd_addr;
      logic            load_i;
      logic            start_pair;
      logic            clear_local;
      logic            clear_total;
      logic            finish_vertex;
      logic            single;
      logic            last_flag;
      logic [IdxW-1:0] out_index;
   } pisd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pair_done;
      logic result_valid;
   } pisd_sts_type;

endpackage

// ===== rtl/pisd_ram.sv =====
module pisd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/pisd_div.sv =====
// floor(2^40 / dsq), restoring, one quotient bit per cycle; dsq == 0 gives all ones
module pisd_div import pisd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DsqW-1:0] dsq,
   output logic            done,
   output logic [ValW-1:0] quot
);
   localparam int Steps = 41;
   localparam int StepW = $clog2(Steps + 1);

   logic [DsqW:0]   rem_ff, rem_in, trial;
   logic [DsqW-1:0] den_ff, den_in;
   logic [40:0]     num_ff, num_in;
   logic [ValW-1:0] q_ff, q_in;
   logic [StepW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in = rem_ff; den_in = den_ff; num_in = num_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         rem_in = '0; den_in = dsq; num_in = 41'h1_0000_0000_00; q_in = '0;
         cnt_in = StepW'(Steps); busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[DsqW-1:0], num_ff[40]};
         num_in = {num_ff[39:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[ValW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[ValW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (den_ff == '0) q_in = Sat48;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; den_ff <= den_in; num_ff <= num_in; q_ff <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== rtl/pisd_datapath.sv =====
module pisd_datapath import pisd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  pisd_cmd_type cmd,
   output pisd_sts_type sts,
   output rsp_type      rsp_data
);
   logic [CoordW-1:0] xr, yr;
   logic signed [CoordW-1:0] xi_ff, yi_ff;
   logic rd_ff, rd_ff2, load_ff;
   logic signed [CoordW:0] dx_ff, dy_ff;
   logic [2*CoordW+1:0] sx_ff, sy_ff;
   logic sq_ff, sum_ff, div_go;
   logic [DsqW-1:0] dsq_ff;
   logic div_done;
   logic [ValW-1:0] quot;
   logic [ValW-1:0] local_ff, total_ff;
   logic lsat_ff, tsat_ff;
   logic [ValW:0] lsum, tsum;
   rsp_type rsp_ff;
   logic rv_ff;
   logic [CoordW:0] ax, ay;

   pisd_ram #(.Width(CoordW), .Depth(MaxVertices)) u_x (
      .clock(clock), .wr_en(cmd.store_wr), .wr_addr(cmd.store_addr),
      .wr_data(req_data.x_coord), .rd_addr(cmd.rd_addr), .rd_data(xr));
   pisd_ram #(.Width(CoordW), .Depth(MaxVertices)) u_y (
      .clock(clock), .wr_en(cmd.store_wr), .wr_addr(cmd.store_addr),
      .wr_data(req_data.y_coord), .rd_addr(cmd.rd_addr), .rd_data(yr));

   assign ax = dx_ff[CoordW] ? -dx_ff : dx_ff;
   assign ay = dy_ff[CoordW] ? -dy_ff : dy_ff;
   assign lsum = {1'b0, local_ff} + {1'b0, quot};
   assign tsum = {1'b0, total_ff} + {1'b0, local_ff};

   pisd_div u_div (.clock(clock), .reset(reset), .start(div_go), .dsq(dsq_ff),
      .done(div_done), .quot(quot));

   always_ff @(posedge clock) begin
      if (load_ff) begin
         xi_ff <= xr;
         yi_ff <= yr;
      end
      dx_ff <= {xi_ff[CoordW-1], xi_ff} - {xr[CoordW-1], xr};
      dy_ff <= {yi_ff[CoordW-1], yi_ff} - {yr[CoordW-1], yr};
      sx_ff <= ax * ax;
      sy_ff <= ay * ay;
      dsq_ff <= sx_ff + sy_ff;
      if (cmd.clear_local) begin
         local_ff <= '0;
         lsat_ff <= 1'b0;
      end else if (div_done) begin
         if (lsum[ValW]) begin
            local_ff <= Sat48;
            lsat_ff <= 1'b1;
         end else begin
            local_ff <= lsum[ValW-1:0];
         end
         if (quot == Sat48) lsat_ff <= 1'b1;
      end
      if (cmd.clear_total) begin
         total_ff <= '0;
         tsat_ff <= 1'b0;
      end
      if (cmd.single) begin
         rsp_ff <= '{last_result: 1'b1, default: '0};
      end else if (cmd.finish_vertex) begin
         rsp_ff.vertex_index <= cmd.out_index;
         rsp_ff.near_density <= local_ff;
         rsp_ff.last_result <= cmd.last_flag;
         if (tsum[ValW]) begin
            total_ff <= Sat48;
            tsat_ff <= 1'b1;
            rsp_ff.total_score <= Sat48;
            rsp_ff.saturated <= 1'b1;
         end else begin
            total_ff <= tsum[ValW-1:0];
            rsp_ff.total_score <= tsum[ValW-1:0];
            rsp_ff.saturated <= lsat_ff | tsat_ff;
         end
      end
      if (reset) begin
         rd_ff <= 1'b0; rd_ff2 <= 1'b0; load_ff <= 1'b0;
         sq_ff <= 1'b0; sum_ff <= 1'b0; div_go <= 1'b0; rv_ff <= 1'b0;
      end else begin
         // read -> diff -> square -> sum -> divider start
         load_ff <= cmd.load_i;
         rd_ff <= cmd.start_pair;
         rd_ff2 <= rd_ff;
         sq_ff <= rd_ff2;
         sum_ff <= sq_ff;
         div_go <= sum_ff;
         rv_ff <= cmd.single | cmd.finish_vertex;
      end
   end

   assign sts.pair_done = div_done;
   assign sts.result_valid = rv_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== rtl/pisd_ctrl.sv =====
module pisd_ctrl import pisd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  pisd_sts_type sts,
   output pisd_cmd_type cmd
);
   typedef enum logic [2:0] {
      S_LOAD, S_LOADI, S_PAIR, S_WAIT, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in, n_ff, n_in;
   logic [IdxW-1:0] i_ff, i_in, j_ff, j_in;
   logic rv_ff, rv_in, last_ff, last_in;
   logic acc;

   assign req_ready = (state_ff == S_LOAD) && !rv_ff;
   assign acc = req_valid && req_ready;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; n_in = n_ff; i_in = i_ff; j_in = j_ff;
      rv_in = rv_ff; last_in = last_ff;
      cmd = '0;
      cmd.store_addr = cnt_ff[IdxW-1:0];
      cmd.rd_addr = j_ff;
      cmd.out_index = i_ff;
      cmd.last_flag = last_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (sts.result_valid) rv_in = 1'b1;
      case (state_ff)
         S_LOAD: begin
            if (acc) begin
               n_in = cnt_ff;
               if (cnt_ff != CntW'(MaxVertices)) begin
                  cmd.store_wr = 1'b1;
                  n_in = cnt_ff + 1'b1;
               end
               cnt_in = n_in;
               if (req_data.last_vertex) begin
                  cnt_in = '0;
                  cmd.clear_total = 1'b1;
                  i_in = '0;
                  if (n_in <= CntW'(1)) begin
                     cmd.single = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     j_in = '0;
                     state_in = S_LOADI;
                  end
               end
            end
         end
         S_LOADI: begin
            cmd.rd_addr = i_ff;
            cmd.load_i = 1'b1;
            cmd.clear_local = 1'b1;
            j_in = i_ff + 1'b1;
            state_in = S_PAIR;
         end
         S_PAIR: begin
            cmd.start_pair = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (sts.pair_done) begin
               if ({1'b0, j_ff} + 1'b1 == n_ff) begin
                  state_in = S_FIN;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = S_PAIR;
               end
            end
         end
         S_FIN: begin
            if (!rv_ff) begin
               last_in = ({1'b0, i_ff} + 2'd2 == n_ff);
               cmd.last_flag = last_in;
               cmd.finish_vertex = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.result_valid || rv_ff) begin
               if (rv_ff && rsp_ready && !sts.result_valid) begin
                  if (last_ff || n_ff <= CntW'(1)) begin
                     state_in = S_LOAD;
                     last_in = 1'b0;
                  end else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_LOADI;
                  end
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in;
      if (reset) begin
         state_ff <= S_LOAD; cnt_ff <= '0; rv_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; rv_ff <= rv_in; last_ff <= last_in;
      end
   end
endmodule

// ===== rtl/pairwise_inverse_square_density.sv =====
// channel | ports            | payload
// request | req_valid/ready  | req_data  (req_type)
// result  | rsp_valid/ready  | rsp_data  (rsp_type)
// Loading accepts a new vertex whenever req_ready is high; no result for non-last vertices.
// Each pair goes through read, diff, square, sum, then a 41-step divider; pairs run one at a time.
// A set of n vertices runs n*(n-1)/2 pairs: each vertex i is paired with every j > i.
// Results wait in one output register; the next vertex waits for its transfer.
// Reset clears control state only; the coordinate RAMs need no clearing.
module pairwise_inverse_square_density import pisd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   pisd_cmd_type cmd;
   pisd_sts_type sts;

   pisd_ctrl u_ctrl (.clock(clock), .reset(reset), .req_valid(req_valid),
      .req_ready(req_ready), .req_data(req_data), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd));

   pisd_datapath u_dp (.clock(clock), .reset(reset), .req_data(req_data),
      .cmd(cmd), .sts(sts), .rsp_data(rsp_data));
endmodule
